>>> sv/ptwa_pkg.sv
package ptwa_pkg;

  // stream payload widths
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 64;
  localparam int MAX_RESULTS = 16;

  // item opcodes, echoed as result kind
  localparam logic [1:0] OP_BEACON = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_NEW     = 3'd0;
  localparam logic [2:0] STAT_REFRESH = 3'd1;
  localparam logic [2:0] STAT_OWN     = 3'd2;
  localparam logic [2:0] STAT_FULL    = 3'd3;
  localparam logic [2:0] STAT_NONE    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_OWN_IP    = 2'd0;
  localparam logic [1:0] REG_EXPIRE_MS = 2'd1;

  localparam logic [31:0] EXPIRE_RESET = 32'd15000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  // one stored peer
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] seen;
  } entry_t;

  // result payload, status in the lowest bits
  function automatic logic [OUT_DATA_W-1:0] pack_result(
    input logic [2:0]  status,
    input logic [3:0]  slot,
    input logic [31:0] ip,
    input logic [15:0] port,
    input logic        present,
    input logic [4:0]  expired
  );
    pack_result = {3'b000, expired, present, port, ip, slot, status};
  endfunction

endpackage

>>> sv/ptwa_store.sv
module ptwa_store #(
  parameter int ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [((ENTRIES>1)?$clog2(ENTRIES):1)-1:0] rd_idx,
  output ptwa_pkg::entry_t                   rd_entry,
  input  logic                               wr_en,
  input  logic [((ENTRIES>1)?$clog2(ENTRIES):1)-1:0] wr_idx,
  input  ptwa_pkg::entry_t                   wr_entry,
  input  logic [ENTRIES-1:0]                 clr_mask,
  output logic [ENTRIES-1:0]                 used
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  ptwa_pkg::entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] set_vec;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_entry <= mem[rd_idx];
  end

  // one-hot of the written slot
  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      set_vec[j] = wr_en && (wr_idx == IW'(j));
    end
  end

  // used flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= (used & ~clr_mask) | set_vec;
    end
  end

endmodule

>>> sv/peer_table_with_aging.sv
// a beacon or tick reads and evaluates every slot in turn, then passes through commit and emit to its result
// one item at a time: the input is held (tready low) until the sequencer is back in idle
// a list reads and evaluates each slot it scans, and waits in evaluate while the output is stalled
// each entry is read through the registered read port of the entry memory, so each slot needs a read step
// an empty list or an unused opcode goes straight to the emit step and presents its result from there
// reset (synchronous, active high) empties the table and loads own_ip 0, expire_ms 15000
module peer_table_with_aging #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // now_ms, source_ip, source_port
  input  logic [1:0]  s_axis_tuser,  // opcode
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // status, slot, entry_ip, entry_port, entry_present,
                                     // expired_count, zero fill
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [3:0] LIST_LAST_CNT = 4'(ptwa_pkg::MAX_RESULTS - 1);

  ptwa_pkg::state_t state, state_next;

  logic [31:0] own_ip;
  logic [31:0] expire_ms;

  // latched item
  logic [1:0]  op;
  logic [31:0] now;
  logic [31:0] sip;
  logic [15:0] sport;
  logic        own_hit;

  // scan state
  logic [IW-1:0]      idx;
  logic [IW-1:0]      pick;
  logic               pick_valid;
  logic               matched;
  logic [ENTRIES-1:0] exp_vec;
  logic [CW-1:0]      exp_cnt;
  logic [3:0]         list_cnt;
  logic [63:0]        res_data;

  ptwa_pkg::entry_t   rd_entry;
  ptwa_pkg::entry_t   wr_entry;
  logic               wr_en;
  logic [ENTRIES-1:0] clr_mask;
  logic [ENTRIES-1:0] used;

  logic               take_in;
  logic               out_free;
  logic               emit_list;
  logic               emit_res;
  logic               advance;
  logic [31:0]        age;
  logic               is_old;
  logic               ip_hit;
  logic [ENTRIES-1:0] above_mask;
  logic [ENTRIES-1:0] keep_mask;
  logic               later_used;
  logic               last_list;
  logic [3:0]         idx_slot;
  logic [3:0]         pick_slot;
  logic [IW+3:0]      idx_ext;
  logic [IW+3:0]      pick_ext;
  logic [CW-1:0]      cnt_adj;
  logic [CW+4:0]      cnt_ext;
  logic [2:0]         beacon_status;

  ptwa_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk                 (clk),
    .rst                 (rst),
    .rd_idx              (idx),
    .rd_entry            (rd_entry),
    .wr_en               (wr_en),
    .wr_idx              (pick),
    .wr_entry            (wr_entry),
    .clr_mask            (clr_mask),
    .used                (used)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ptwa_pkg::ST_IDLE);
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // shared compare unit: age test and address match on the entry just read
  assign age    = now - rd_entry.seen;
  assign is_old = used[idx] && (age > expire_ms);
  assign ip_hit = used[idx] && (rd_entry.ip == sip);

  // masks over the slot vector
  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      above_mask[j] = (IW'(j) > idx);
      keep_mask[j]  = matched && (pick == IW'(j));
    end
  end

  assign later_used = |(used & above_mask);
  assign last_list  = (list_cnt == LIST_LAST_CNT) || !later_used;

  // slot field carries the low four bits of the index
  assign idx_ext   = {4'b0000, idx};
  assign pick_ext  = {4'b0000, pick};
  assign idx_slot  = idx_ext[3:0];
  assign pick_slot = pick_ext[3:0];

  // refreshed entry was counted as old before it was rewritten
  assign cnt_adj = exp_cnt - CW'(matched && exp_vec[pick]);
  assign cnt_ext = {5'b00000, cnt_adj};

  always_comb begin
    priority if (own_hit) begin
      beacon_status = ptwa_pkg::STAT_OWN;
    end else if (!pick_valid) begin
      beacon_status = ptwa_pkg::STAT_FULL;
    end else if (matched) begin
      beacon_status = ptwa_pkg::STAT_REFRESH;
    end else begin
      beacon_status = ptwa_pkg::STAT_NEW;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptwa_pkg::ST_IDLE: begin
        if (take_in) begin
          unique case (s_axis_tuser)
            ptwa_pkg::OP_BEACON,
            ptwa_pkg::OP_TICK: state_next = ptwa_pkg::ST_READ;
            ptwa_pkg::OP_LIST: state_next = (used == '0) ? ptwa_pkg::ST_EMIT
                                                         : ptwa_pkg::ST_READ;
            default:           state_next = ptwa_pkg::ST_EMIT;
          endcase
        end
      end
      ptwa_pkg::ST_READ: state_next = ptwa_pkg::ST_EVAL;
      ptwa_pkg::ST_EVAL: begin
        if (op == ptwa_pkg::OP_LIST) begin
          if (used[idx]) begin
            if (out_free) begin
              state_next = last_list ? ptwa_pkg::ST_IDLE : ptwa_pkg::ST_READ;
            end
          end else begin
            state_next = (idx == LAST_IDX) ? ptwa_pkg::ST_IDLE : ptwa_pkg::ST_READ;
          end
        end else begin
          state_next = (idx == LAST_IDX) ? ptwa_pkg::ST_COMMIT : ptwa_pkg::ST_READ;
        end
      end
      ptwa_pkg::ST_COMMIT: state_next = ptwa_pkg::ST_EMIT;
      ptwa_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = ptwa_pkg::ST_IDLE;
        end
      end
      default: state_next = ptwa_pkg::ST_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    emit_list     = (state == ptwa_pkg::ST_EVAL) && (op == ptwa_pkg::OP_LIST)
                    && used[idx] && out_free;
    emit_res      = (state == ptwa_pkg::ST_EMIT) && out_free;
    advance       = (state == ptwa_pkg::ST_EVAL) && (state_next == ptwa_pkg::ST_READ);
    wr_en         = (state == ptwa_pkg::ST_COMMIT) && (op == ptwa_pkg::OP_BEACON)
                    && !own_hit && pick_valid;
    clr_mask      = (state == ptwa_pkg::ST_COMMIT) ? (exp_vec & ~keep_mask) : '0;
    wr_entry.ip   = sip;
    wr_entry.port = sport;
    wr_entry.seen = now;
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ptwa_pkg::ST_IDLE;
      own_ip        <= '0;
      expire_ms     <= ptwa_pkg::EXPIRE_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ptwa_pkg::REG_OWN_IP) begin
          own_ip <= cfg_data;
        end
        if (cfg_index == ptwa_pkg::REG_EXPIRE_MS) begin
          expire_ms <= cfg_data;
        end
      end
      if (emit_list || emit_res) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // item, scan and result registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      op         <= s_axis_tuser;
      now        <= s_axis_tdata[31:0];
      sip        <= s_axis_tdata[63:32];
      sport      <= s_axis_tdata[79:64];
      own_hit    <= (s_axis_tdata[63:32] == own_ip);
      idx        <= '0;
      pick       <= '0;
      pick_valid <= 1'b0;
      matched    <= 1'b0;
      exp_vec    <= '0;
      exp_cnt    <= '0;
      list_cnt   <= '0;
      res_data   <= ptwa_pkg::pack_result(ptwa_pkg::STAT_NONE, 4'd0, 32'd0, 16'd0,
                                          1'b0, 5'd0);
    end
    // sweep and match on the entry read; a dropped beacon only sweeps
    if ((state == ptwa_pkg::ST_EVAL) && (op != ptwa_pkg::OP_LIST)) begin
      if (is_old) begin
        exp_vec[idx] <= 1'b1;
        exp_cnt      <= exp_cnt + CW'(1);
      end
      if ((op == ptwa_pkg::OP_BEACON) && !own_hit && !matched) begin
        if (ip_hit) begin
          pick       <= idx;
          pick_valid <= 1'b1;
          matched    <= 1'b1;
        end else if (!used[idx] && !pick_valid) begin
          pick       <= idx;
          pick_valid <= 1'b1;
        end
      end
    end
    if (advance) begin
      idx <= idx + IW'(1);
    end
    if (emit_list) begin
      list_cnt <= list_cnt + 4'd1;
    end
    if (state == ptwa_pkg::ST_COMMIT) begin
      res_data <= ptwa_pkg::pack_result(
        (op == ptwa_pkg::OP_BEACON) ? beacon_status : ptwa_pkg::STAT_NONE,
        wr_en ? pick_slot : 4'd0, 32'd0, 16'd0, 1'b0, cnt_ext[4:0]);
    end
    // output register
    if (emit_list) begin
      m_axis_tdata <= ptwa_pkg::pack_result(ptwa_pkg::STAT_NONE, idx_slot, rd_entry.ip,
                                            rd_entry.port, 1'b1, 5'd0);
      m_axis_tuser <= op;
      m_axis_tlast <= last_list;
    end else if (emit_res) begin
      m_axis_tdata <= res_data;
      m_axis_tuser <= op;
      m_axis_tlast <= 1'b1;
    end
  end

  // the commit step always hands a result to the emit step
  a_commit_emit: assert property (@(posedge clk) disable iff (rst)
    state == ptwa_pkg::ST_COMMIT |=> state == ptwa_pkg::ST_EMIT)
    else $error("commit not followed by emit");

  // the running sweep count matches the marked entries
  a_sweep_count: assert property (@(posedge clk) disable iff (rst)
    ((state == ptwa_pkg::ST_READ) || (state == ptwa_pkg::ST_EVAL))
    && ((op == ptwa_pkg::OP_BEACON) || (op == ptwa_pkg::OP_TICK))
    |-> (exp_cnt == CW'($countones(exp_vec))))
    else $error("sweep count out of step with marked entries");

  // only used entries are freed
  a_clear_used: assert property (@(posedge clk) disable iff (rst)
    state == ptwa_pkg::ST_COMMIT |-> ((exp_vec & ~used) == '0))
    else $error("sweep frees an entry that is not used");

  // a new entry lands in a free slot
  a_new_free: assert property (@(posedge clk) disable iff (rst)
    (state == ptwa_pkg::ST_COMMIT) && pick_valid && !matched |-> !used[pick])
    else $error("new entry overwrites a used slot");

endmodule

>>> tb/sv/peer_table_with_aging_checker.sv
`timescale 1ns / 100ps

module peer_table_with_aging_checker #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // now_ms, source_ip, source_port
  input  logic [1:0]  s_axis_tuser,  // opcode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,  // status, slot, entry_ip, entry_port, entry_present,
                                     // expired_count, zero fill
  input  logic [1:0]  m_axis_tuser,  // kind
  input  logic        m_axis_tlast,
  output int          awaited_count,
  output int          mismatch_count
);

  localparam int REPORT_LIMIT = 10;

  // one result as seen on the output stream
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] ip;
    logic [15:0] port;
    logic        present;
    logic [4:0]  expired;
    logic        last;
  } peer_result_t;

  // shadow of the peer table and its registers
  logic        peer_used [ENTRIES];
  logic [31:0] peer_addr [ENTRIES];
  logic [15:0] peer_port [ENTRIES];
  logic [31:0] peer_seen [ENTRIES];
  logic [31:0] own_addr;
  logic [31:0] expire_limit;

  peer_result_t awaited_results [$];
  int errs;

  function automatic string show(input peer_result_t r);
    show = $sformatf({"kind %0d status %0d slot %0d ip %h port %h ",
                      "present %0b expired %0d last %0b"},
                     r.kind, r.status, r.slot, r.ip, r.port, r.present, r.expired, r.last);
  endfunction

  // free every used entry older than the limit, return how many went
  function automatic logic [4:0] age_out(input logic [31:0] now);
    int i;
    int freed;
    logic [31:0] age;
    freed = 0;
    for (i = 0; i < ENTRIES; i++) begin
      age = now - peer_seen[i];
      if (peer_used[i] && age > expire_limit) begin
        peer_used[i] = 1'b0;
        freed++;
      end
    end
    age_out = freed[4:0];
  endfunction

  // learn, age or list for one accepted item and queue what it should produce
  task automatic peer_table_step(input logic [1:0] op, input logic [31:0] now,
                                 input logic [31:0] sip, input logic [15:0] sport);
    peer_result_t r;
    int i;
    int pick;
    int total;
    int listed;
    logic hit;
    r = '0;
    r.kind = op;
    r.status = ptwa_pkg::STAT_NONE;
    r.last = 1'b1;
    case (op)
      ptwa_pkg::OP_BEACON: begin
        if (sip == own_addr) begin
          r.status = ptwa_pkg::STAT_OWN;
        end else begin
          pick = -1;
          hit = 1'b0;
          // a match anywhere wins over an earlier free slot
          for (i = 0; i < ENTRIES; i++) begin
            if (!hit && peer_used[i] && peer_addr[i] == sip) begin
              pick = i;
              hit = 1'b1;
            end else if (!hit && !peer_used[i] && pick < 0) begin
              pick = i;
            end
          end
          if (pick < 0) begin
            r.status = ptwa_pkg::STAT_FULL;
          end else begin
            peer_used[pick] = 1'b1;
            peer_addr[pick] = sip;
            peer_port[pick] = sport;
            peer_seen[pick] = now;
            r.slot = pick[3:0];
            r.status = hit ? ptwa_pkg::STAT_REFRESH : ptwa_pkg::STAT_NEW;
          end
        end
        r.expired = age_out(now);
        awaited_results.push_back(r);
      end
      ptwa_pkg::OP_TICK: begin
        r.expired = age_out(now);
        awaited_results.push_back(r);
      end
      ptwa_pkg::OP_LIST: begin
        total = 0;
        for (i = 0; i < ENTRIES; i++)
          if (peer_used[i]) total++;
        if (total > ptwa_pkg::MAX_RESULTS) total = ptwa_pkg::MAX_RESULTS;
        if (total == 0) begin
          awaited_results.push_back(r);
        end else begin
          listed = 0;
          for (i = 0; i < ENTRIES; i++) begin
            if (peer_used[i] && listed < total) begin
              r.slot = i[3:0];
              r.ip = peer_addr[i];
              r.port = peer_port[i];
              r.present = 1'b1;
              r.last = (listed == total - 1);
              awaited_results.push_back(r);
              listed++;
            end
          end
        end
      end
      default: begin
        // unused opcode answers once and leaves the table alone
        awaited_results.push_back(r);
      end
    endcase
  endtask

  task automatic check_result();
    peer_result_t got;
    peer_result_t want;
    got.kind = m_axis_tuser;
    got.status = m_axis_tdata[2:0];
    got.slot = m_axis_tdata[6:3];
    got.ip = m_axis_tdata[38:7];
    got.port = m_axis_tdata[54:39];
    got.present = m_axis_tdata[55];
    got.expired = m_axis_tdata[60:56];
    got.last = m_axis_tlast;
    if (awaited_results.size() == 0) begin
      errs++;
      if (errs <= REPORT_LIMIT) $display("unexpected result: %s", show(got));
    end else begin
      want = awaited_results.pop_front();
      if (got !== want) begin
        errs++;
        if (errs <= REPORT_LIMIT) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    end
  endtask

  // watch all three channels on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        peer_used[i] = 1'b0;
        peer_addr[i] = '0;
        peer_port[i] = '0;
        peer_seen[i] = '0;
      end
      own_addr = '0;
      expire_limit = ptwa_pkg::EXPIRE_RESET;
      awaited_results.delete();
      errs = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ptwa_pkg::REG_OWN_IP:    own_addr = cfg_data;
          ptwa_pkg::REG_EXPIRE_MS: expire_limit = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        peer_table_step(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                        s_axis_tdata[79:64]);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    awaited_count <= awaited_results.size();
    mismatch_count <= errs;
  end

endmodule

>>> tb/sv/peer_table_with_aging_tb.sv
`timescale 1ns / 100ps

module peer_table_with_aging_tb;

  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [31:0] OWN_DIRECTED  = 32'hC0A8_0001;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          PHASE_ITEMS   = 100;
  localparam int          POOL_SIZE     = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // now_ms, source_ip, source_port
  logic [1:0]  s_axis_tuser = '0;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // status, slot, entry_ip, entry_port, entry_present,
                                   // expired_count, zero fill
  logic [1:0]  m_axis_tuser;       // kind
  logic        m_axis_tlast;

  int awaited_count;
  int mismatch_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  // stimulus side view of time and registers, used only to shape items
  logic [31:0] clock_ms = '0;
  logic [31:0] own_cfg = '0;
  logic [31:0] expire_cfg = ptwa_pkg::EXPIRE_RESET;
  logic [31:0] peer_pool [POOL_SIZE];

  always #2 clk = ~clk;

  peer_table_with_aging #(.ENTRIES(16)) uut (.*);

  peer_table_with_aging_checker #(.ENTRIES(16)) peer_check (.*);

  // receiver backpressure and run watchdog
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // present one item, with random gaps ahead of it, and wait for its transfer
  task automatic send_item(input logic [1:0] op, input logic [31:0] now,
                           input logic [31:0] ip, input logic [15:0] port);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {port, ip, now};
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop sending and wait until every awaited result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int pick;
    logic [1:0] op;
    logic [31:0] ip;
    logic [31:0] step_cap;
    pick = $urandom_range(0, 99);
    step_cap = (expire_cfg > 32'd40000) ? 32'd8000 : expire_cfg / 3 + 1;
    // mostly small time steps, sometimes exactly the limit or a wild jump
    case ($urandom_range(0, 19))
      0: clock_ms = $urandom;
      1: clock_ms = clock_ms + expire_cfg;
      default: clock_ms = clock_ms + $urandom_range(0, step_cap);
    endcase
    // small address pool so that refreshes and a full table happen
    case ($urandom_range(0, 9))
      0: ip = own_cfg;
      1: ip = $urandom;
      default: ip = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
    endcase
    if (pick < 55) op = ptwa_pkg::OP_BEACON;
    else if (pick < 80) op = ptwa_pkg::OP_TICK;
    else if (pick < 92) op = ptwa_pkg::OP_LIST;
    else if (pick < 95) op = OP_UNUSED;
    else begin
      // noise: any opcode, any time, any address
      op = 2'($urandom_range(0, 3));
      clock_ms = $urandom;
      ip = $urandom;
    end
    send_item(op, clock_ms, ip, 16'($urandom_range(0, 16'hFFFF)));
  endtask

  initial begin : stimulus
    int ph;
    int n;
    int k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    own_cfg = OWN_DIRECTED;
    expire_cfg = ptwa_pkg::EXPIRE_RESET;
    write_reg(ptwa_pkg::REG_OWN_IP, own_cfg);
    write_reg(ptwa_pkg::REG_EXPIRE_MS, expire_cfg);

    // directed: empty list, own address, extremes of address and port
    send_item(ptwa_pkg::OP_LIST, 32'd0, 32'd0, 16'd0);
    send_item(ptwa_pkg::OP_BEACON, 32'd0, OWN_DIRECTED, 16'd80);
    send_item(ptwa_pkg::OP_BEACON, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(ptwa_pkg::OP_BEACON, 32'd1, 32'd0, 16'd0);
    send_item(ptwa_pkg::OP_BEACON, 32'd100, 32'd0, 16'd1234);
    send_item(ptwa_pkg::OP_LIST, 32'd100, 32'd0, 16'd0);
    // age exactly at the limit stays, one past it goes
    send_item(ptwa_pkg::OP_TICK, 32'd15000, 32'd0, 16'd0);
    send_item(ptwa_pkg::OP_TICK, 32'd15001, 32'd0, 16'd0);
    // refresh of slot one while slot zero is free
    send_item(ptwa_pkg::OP_BEACON, 32'd15001, 32'd0, 16'h8000);
    // fill the table, then one more is refused
    for (k = 0; k < 15; k++)
      send_item(ptwa_pkg::OP_BEACON, 32'd15002, 32'h0A00_0000 + k, k[15:0]);
    send_item(ptwa_pkg::OP_BEACON, 32'd15003, 32'h0A00_00FF, 16'd7);
    send_item(ptwa_pkg::OP_LIST, 32'd15003, 32'd0, 16'd0);
    send_item(OP_UNUSED, $urandom, $urandom, 16'hBEEF);
    // wrapped time far ahead frees every entry at once
    send_item(ptwa_pkg::OP_TICK, 32'hFFFF_FFFF, 32'd0, 16'd0);

    // random phases with different registers and idling
    for (ph = 0; ph < 4; ph++) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (ph)
        0: begin
          own_cfg = $urandom;
          expire_cfg = ptwa_pkg::EXPIRE_RESET;
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          own_cfg = 32'd0;
          expire_cfg = 32'd1;
          send_idle_pct = 66;
          recv_stall_pct = 0;
        end
        2: begin
          own_cfg = 32'hFFFF_FFFF;
          expire_cfg = 32'hFFFF_FFFF;
          send_idle_pct = 0;
          recv_stall_pct = 66;
        end
        default: begin
          own_cfg = $urandom;
          expire_cfg = $urandom_range(500, 20000);
          send_idle_pct = 19;
          recv_stall_pct = 19;
        end
      endcase
      write_reg(ptwa_pkg::REG_OWN_IP, own_cfg);
      write_reg(ptwa_pkg::REG_EXPIRE_MS, expire_cfg);
      for (k = 0; k < POOL_SIZE; k++) peer_pool[k] = $urandom;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain();
        send_random_item();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
